/* rtl/lcw_pkg.sv */
// Shared types, constants and lookup tables for the LCD character writer.
`timescale 1ns / 1ps
package lcw_pkg;

   localparam int CACHE_SLOTS = 8;
   localparam int LINE_CHARS  = 8;
   localparam int GLYPH_ROWS  = 8;
   localparam int GLYPH_COUNT = 30;
   localparam int ROM_GLYPHS  = 30;

   localparam int SLOT_W = 3;
   localparam int ROW_W  = $clog2(GLYPH_ROWS);
   localparam int PC_W   = 4;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_SETPOS = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_INIT   = 2'd3;

   localparam logic [7:0] BYTE_CLEAR = 8'h01;
   localparam logic [7:0] BYTE_HOME  = 8'h02;
   localparam logic [7:0] BYTE_FUNC  = 8'h38;
   localparam logic [7:0] BYTE_DISP  = 8'h0E;
   localparam logic [7:0] BYTE_ENTRY = 8'h06;
   localparam logic [7:0] BYTE_DDRAM = 8'h80;
   localparam logic [7:0] BYTE_LINE2 = 8'hC0;
   localparam logic [7:0] BYTE_CGRAM = 8'h40;
   localparam logic [7:0] CGRAM_MASK = 8'hF8;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [6:0] LINE2_ADDR = 7'h40;

   // microcode step addresses
   localparam logic [PC_W-1:0] STEP_IDLE       = 4'd0;
   localparam logic [PC_W-1:0] STEP_RESOLVE    = 4'd1;
   localparam logic [PC_W-1:0] STEP_CG_ADDR    = 4'd2;
   localparam logic [PC_W-1:0] STEP_CG_ROW     = 4'd3;
   localparam logic [PC_W-1:0] STEP_RESTORE    = 4'd4;
   localparam logic [PC_W-1:0] STEP_CHAR       = 4'd5;
   localparam logic [PC_W-1:0] STEP_LINE2      = 4'd6;
   localparam logic [PC_W-1:0] STEP_SETPOS     = 4'd7;
   localparam logic [PC_W-1:0] STEP_CLEAR      = 4'd8;
   localparam logic [PC_W-1:0] STEP_INIT_CLEAR = 4'd9;
   localparam logic [PC_W-1:0] STEP_INIT_HOME  = 4'd10;
   localparam logic [PC_W-1:0] STEP_INIT_FUNC  = 4'd11;
   localparam logic [PC_W-1:0] STEP_INIT_DISP  = 4'd12;
   localparam logic [PC_W-1:0] STEP_INIT_ENTRY = 4'd13;
   localparam logic [PC_W-1:0] STEP_HOME       = 4'd14;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
      logic [3:0] position;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] ctrl_byte;
      logic       register_select;
      logic       long_wait;
      logic       last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      SRC_CONST, SRC_CHAR, SRC_CGRAM, SRC_ROW, SRC_CURSOR, SRC_POS
   } src_type;

   typedef enum logic [1:0] {
      LAST_NO, LAST_YES, LAST_NOWRAP
   } last_type;

   typedef enum logic [1:0] {
      CUR_KEEP, CUR_ZERO, CUR_POS, CUR_ADV
   } cur_op_type;

   typedef enum logic [2:0] {
      JMP_NEXT, JMP_GOTO, JMP_DISPATCH, JMP_NO_LOAD, JMP_ROW_MORE, JMP_NO_WRAP
   } jmp_type;

   typedef struct packed {
      logic            wait_req;
      logic            emit;
      src_type         src;
      logic [7:0]      const_byte;
      logic            rs;
      last_type        last;
      cur_op_type      cur_op;
      logic            slots_clear;
      logic            resolve;
      logic            row_inc;
      jmp_type         jmp;
      logic [PC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      uword_type uw;
      logic      go;
   } seq_ctrl_type;

   typedef struct packed {
      logic load;
      logic row_more;
      logic wrap;
      logic out_ok;
   } dp_status_type;

   // glyph number for codes 128..255, 0 = no glyph
   localparam logic [4:0] CHAR_GLYPH_ROM [128] = '{
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd1, 5'd0, 5'd2, 5'd0, 5'd0, 5'd3, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd4, 5'd0, 5'd5, 5'd0, 5'd0, 5'd6, 5'd0,
      5'd0, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd8, 5'd9, 5'd0, 5'd0, 5'd10, 5'd11, 5'd0, 5'd12,
      5'd0, 5'd0, 5'd13, 5'd14, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd15, 5'd16, 5'd17, 5'd0, 5'd0, 5'd18, 5'd0, 5'd0,
      5'd0, 5'd19, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd20, 5'd21, 5'd0, 5'd0, 5'd22, 5'd23, 5'd0, 5'd24,
      5'd0, 5'd0, 5'd25, 5'd26, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd27, 5'd28, 5'd29, 5'd0, 5'd0, 5'd30, 5'd0, 5'd0
   };

   // bitmap rows, GLYPH_ROWS per glyph, glyph 1 first
   localparam logic [4:0] GLYPH_ROW_ROM [ROM_GLYPHS * GLYPH_ROWS] = '{
      5'h0A, 5'h04, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E, 5'h00,
      5'h0A, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00,
      5'h0A, 5'h04, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F, 5'h00,
      5'h0A, 5'h04, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E, 5'h00,
      5'h09, 5'h1D, 5'h08, 5'h08, 5'h08, 5'h09, 5'h06, 5'h00,
      5'h0A, 5'h04, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F, 5'h00,
      5'h02, 5'h04, 5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h00,
      5'h0A, 5'h04, 5'h0E, 5'h10, 5'h10, 5'h11, 5'h0E, 5'h00,
      5'h02, 5'h04, 5'h1F, 5'h10, 5'h1F, 5'h10, 5'h1F, 5'h00,
      5'h0A, 5'h04, 5'h1F, 5'h10, 5'h1F, 5'h10, 5'h1F, 5'h00,
      5'h02, 5'h04, 5'h0E, 5'h04, 5'h04, 5'h04, 5'h0E, 5'h00,
      5'h0A, 5'h04, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E, 5'h00,
      5'h0A, 5'h04, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h00,
      5'h02, 5'h04, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00,
      5'h0A, 5'h04, 5'h1E, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h00,
      5'h06, 5'h06, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00,
      5'h02, 5'h04, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00,
      5'h02, 5'h04, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h00,
      5'h02, 5'h04, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F, 5'h00,
      5'h0A, 5'h04, 5'h0E, 5'h10, 5'h10, 5'h11, 5'h0E, 5'h00,
      5'h02, 5'h04, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E, 5'h00,
      5'h0A, 5'h04, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E, 5'h00,
      5'h02, 5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E, 5'h00,
      5'h03, 5'h03, 5'h0A, 5'h16, 5'h12, 5'h16, 5'h0A, 5'h00,
      5'h0A, 5'h04, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11, 5'h00,
      5'h02, 5'h04, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00,
      5'h0A, 5'h04, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10, 5'h00,
      5'h06, 5'h06, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D, 5'h00,
      5'h02, 5'h04, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D, 5'h00,
      5'h02, 5'h04, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E, 5'h00
   };

endpackage

/* rtl/lcw_seq.sv */
// Microcode sequencer: step counter, control ROM and jump logic.
`timescale 1ns / 1ps
module lcw_seq
   import lcw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  req_payload_type req_payload,
   output logic            req_stall,
   input  dp_status_type   status,
   output seq_ctrl_type    ctrl
);

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{wait_req: 1'b0, emit: 1'b0, src: SRC_CONST, const_byte: 8'h00, rs: 1'b0,
            last: LAST_NO, cur_op: CUR_KEEP, slots_clear: 1'b0, resolve: 1'b0,
            row_inc: 1'b0, jmp: JMP_GOTO, target: STEP_IDLE};
      unique case (pc)
         STEP_IDLE: begin
            w.wait_req = 1'b1;
            w.jmp      = JMP_DISPATCH;
         end
         STEP_RESOLVE: begin
            w.resolve = 1'b1;
            w.jmp     = JMP_NO_LOAD;
            w.target  = STEP_CHAR;
         end
         STEP_CG_ADDR: begin
            w.emit = 1'b1;
            w.src  = SRC_CGRAM;
            w.jmp  = JMP_NEXT;
         end
         STEP_CG_ROW: begin
            w.emit    = 1'b1;
            w.src     = SRC_ROW;
            w.rs      = 1'b1;
            w.row_inc = 1'b1;
            w.jmp     = JMP_ROW_MORE;
            w.target  = STEP_CG_ADDR;
         end
         STEP_RESTORE: begin
            w.emit = 1'b1;
            w.src  = SRC_CURSOR;
            w.jmp  = JMP_NEXT;
         end
         STEP_CHAR: begin
            w.emit   = 1'b1;
            w.src    = SRC_CHAR;
            w.rs     = 1'b1;
            w.last   = LAST_NOWRAP;
            w.cur_op = CUR_ADV;
            w.jmp    = JMP_NO_WRAP;
            w.target = STEP_IDLE;
         end
         STEP_LINE2: begin
            w.emit       = 1'b1;
            w.const_byte = BYTE_LINE2;
            w.last       = LAST_YES;
         end
         STEP_SETPOS: begin
            w.emit   = 1'b1;
            w.src    = SRC_POS;
            w.last   = LAST_YES;
            w.cur_op = CUR_POS;
         end
         STEP_CLEAR: begin
            w.emit       = 1'b1;
            w.const_byte = BYTE_CLEAR;
            w.target     = STEP_HOME;
         end
         STEP_INIT_CLEAR: begin
            w.emit       = 1'b1;
            w.const_byte = BYTE_CLEAR;
            w.jmp        = JMP_NEXT;
         end
         STEP_INIT_HOME: begin
            w.emit       = 1'b1;
            w.const_byte = BYTE_HOME;
            w.jmp        = JMP_NEXT;
         end
         STEP_INIT_FUNC: begin
            w.emit       = 1'b1;
            w.const_byte = BYTE_FUNC;
            w.jmp        = JMP_NEXT;
         end
         STEP_INIT_DISP: begin
            w.emit       = 1'b1;
            w.const_byte = BYTE_DISP;
            w.jmp        = JMP_NEXT;
         end
         STEP_INIT_ENTRY: begin
            w.emit       = 1'b1;
            w.const_byte = BYTE_ENTRY;
            w.jmp        = JMP_NEXT;
         end
         STEP_HOME: begin
            w.emit        = 1'b1;
            w.const_byte  = BYTE_DDRAM;
            w.last        = LAST_YES;
            w.cur_op      = CUR_ZERO;
            w.slots_clear = 1'b1;
         end
         default: begin
            w.jmp = JMP_GOTO;
         end
      endcase
      return w;
   endfunction

   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       uw;
   logic            go;
   logic [PC_W-1:0] dispatch;

   assign uw = ucode_rom(pc_ff);

   // a step completes when its handshake (if any) lets it
   always_comb begin
      if (uw.wait_req) begin
         go = req_valid;
      end else if (uw.emit) begin
         go = status.out_ok;
      end else begin
         go = 1'b1;
      end
   end

   always_comb begin
      unique case (req_payload.command)
         CMD_WRITE:  dispatch = STEP_RESOLVE;
         CMD_SETPOS: dispatch = STEP_SETPOS;
         CMD_CLEAR:  dispatch = STEP_CLEAR;
         CMD_INIT:   dispatch = STEP_INIT_CLEAR;
         default:    dispatch = STEP_IDLE;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (go) begin
         unique case (uw.jmp)
            JMP_NEXT:     pc_in = pc_ff + 1'b1;
            JMP_GOTO:     pc_in = uw.target;
            JMP_DISPATCH: pc_in = dispatch;
            JMP_NO_LOAD:  pc_in = status.load ? pc_ff + 1'b1 : uw.target;
            JMP_ROW_MORE: pc_in = status.row_more ? uw.target : pc_ff + 1'b1;
            JMP_NO_WRAP:  pc_in = status.wrap ? pc_ff + 1'b1 : uw.target;
            default:      pc_in = STEP_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign req_stall = !uw.wait_req;
   assign ctrl.uw   = uw;
   assign ctrl.go   = go;

   // a transaction's final write always hands control back to the idle step
   assert property (@(posedge clock) disable iff (reset)
      go && uw.emit && uw.last == LAST_YES |=> pc_ff == STEP_IDLE)
      else $error("sequencer did not return to idle after final write");

   // new requests are only taken between transactions
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> pc_ff != STEP_IDLE || $past(pc_ff) == STEP_IDLE)
      else $error("request accepted outside idle step");

endmodule

/* rtl/lcw_dp.sv */
// Datapath: request latch, cursor, glyph slot table, ROM lookups, output register.
`timescale 1ns / 1ps
module lcw_dp
   import lcw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  seq_ctrl_type    ctrl,
   output dp_status_type   status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   req_payload_type item_ff;
   logic [6:0]       cursor_ff, cursor_in;
   logic [4:0]       glyph_slots_ff [CACHE_SLOTS];
   logic [7:0]       char_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [4:0]       glyph_ff;
   logic [ROW_W-1:0] row_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic [4:0]        glyph;
   logic              glyph_ok;
   logic              hit, free_found;
   logic [SLOT_W-1:0] hit_idx, free_idx;
   logic [7:0]        resolved;
   logic              load;
   logic [6:0]        cursor_next;
   logic              wrap;
   logic [6:0]        pos_ext, pos_addr;
   logic [7:0]        out_byte;
   logic              out_last;
   logic              out_ok;
   logic [7:0]        row_index;
   logic [4:0]        glyph_base;

   // glyph lookup and slot search for the latched character
   assign glyph    = CHAR_GLYPH_ROM[item_ff.char_code[6:0]];
   assign glyph_ok = item_ff.char_code[7] && glyph != 5'd0 &&
                     glyph <= 5'(GLYPH_COUNT) && glyph <= 5'(ROM_GLYPHS);

   always_comb begin
      hit        = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      // downward scan so the lowest slot wins
      for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
         if (glyph_slots_ff[i] == glyph) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (glyph_slots_ff[i] == 5'd0) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      load = 1'b0;
      if (!glyph_ok) begin
         resolved = item_ff.char_code;
      end else if (hit) begin
         resolved = 8'(hit_idx);
      end else if (free_found) begin
         resolved = 8'(free_idx);
         load     = 1'b1;
      end else begin
         resolved = SPACE_CHAR;
      end
   end

   assign cursor_next = cursor_ff + 7'd1;
   assign wrap        = cursor_next == 7'(LINE_CHARS);

   always_comb begin
      pos_ext = 7'(item_ff.position);
      if (pos_ext < 7'(LINE_CHARS)) begin
         pos_addr = pos_ext;
      end else begin
         pos_addr = LINE2_ADDR + pos_ext - 7'(LINE_CHARS);
      end
   end

   assign glyph_base = glyph_ff - 5'd1;
   assign row_index  = {glyph_base, row_ff};

   always_comb begin
      unique case (ctrl.uw.src)
         SRC_CONST:  out_byte = ctrl.uw.const_byte;
         SRC_CHAR:   out_byte = char_ff;
         SRC_CGRAM:  out_byte = ((BYTE_CGRAM | {2'b00, slot_ff, 3'b000}) & CGRAM_MASK)
                                | 8'(row_ff);
         SRC_ROW:    out_byte = 8'(GLYPH_ROW_ROM[row_index]);
         SRC_CURSOR: out_byte = BYTE_DDRAM | {1'b0, cursor_ff};
         SRC_POS:    out_byte = BYTE_DDRAM | {1'b0, pos_addr};
         default:    out_byte = 8'h00;
      endcase
   end

   always_comb begin
      unique case (ctrl.uw.last)
         LAST_NO:     out_last = 1'b0;
         LAST_YES:    out_last = 1'b1;
         LAST_NOWRAP: out_last = !wrap;
         default:     out_last = 1'b0;
      endcase
   end

   assign out_ok = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_data_in.ctrl_byte       = out_byte;
      rsp_data_in.register_select = ctrl.uw.rs;
      rsp_data_in.long_wait       = !ctrl.uw.rs &&
                                    (out_byte == BYTE_CLEAR || out_byte == BYTE_HOME);
      rsp_data_in.last            = out_last;
   end

   always_comb begin
      if (ctrl.go && ctrl.uw.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      if (ctrl.go) begin
         unique case (ctrl.uw.cur_op)
            CUR_KEEP: cursor_in = cursor_ff;
            CUR_ZERO: cursor_in = 7'd0;
            CUR_POS:  cursor_in = pos_addr;
            CUR_ADV:  cursor_in = wrap ? LINE2_ADDR : cursor_next;
            default:  cursor_in = cursor_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= 7'd0;
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            glyph_slots_ff[i] <= 5'd0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cursor_ff    <= cursor_in;
         if (ctrl.go && ctrl.uw.slots_clear) begin
            for (int i = 0; i < CACHE_SLOTS; i++) begin
               glyph_slots_ff[i] <= 5'd0;
            end
         end else if (ctrl.go && ctrl.uw.resolve && load) begin
            glyph_slots_ff[free_idx] <= glyph;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.go && ctrl.uw.wait_req) begin
         item_ff <= req_payload;
      end
      if (ctrl.go && ctrl.uw.resolve) begin
         char_ff  <= resolved;
         slot_ff  <= free_idx;
         glyph_ff <= glyph;
         row_ff   <= '0;
      end else if (ctrl.go && ctrl.uw.row_inc) begin
         row_ff <= row_ff + 1'b1;
      end
      if (ctrl.go && ctrl.uw.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.load     = load;
   assign status.row_more = row_ff != ROW_W'(GLYPH_ROWS - 1);
   assign status.wrap     = wrap;
   assign status.out_ok   = out_ok;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.go && ctrl.uw.emit))
      else $error("result appeared without an emitting step");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.go && ctrl.uw.emit && ctrl.uw.src == SRC_ROW |->
         glyph_ff != 5'd0 && glyph_ff <= 5'(GLYPH_COUNT))
      else $error("bitmap row read for an invalid glyph");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.go && ctrl.uw.row_inc && !status.row_more |=> row_ff == '0)
      else $error("row counter not back at zero after glyph load");

endmodule

/* rtl/lcd_char_writer_glyph_cache.sv */
// Top level of the LCD character writer with custom-glyph cache.
//
// Request channel (req_*): one transaction carries a command (write character,
// set position, clear, initialize) with a character code and a position.
// Result channel (rsp_*): one transaction per raw controller write: byte,
// register select, long-wait flag (clear/home commands) and a last flag that
// marks the final write of the request.
// Requests are taken only between requests; the output register lets the
// next request be accepted while the final write still waits to be taken.
// Steps per request (one write per emitting step): set position writes the
// DDRAM address; clear writes clear, then DDRAM address 0; initialize writes
// clear, home, function set, display, entry mode, then DDRAM address 0; a
// character hit or plain character has the cache lookup step, then the
// character write (and a line change on wrap); a miss adds 16 CGRAM writes
// and a cursor restore between the lookup and the character write.
// A stalled result holds the sequencer on its current emitting step.
// Reset (synchronous) puts the cursor at 0, empties all cache slots and
// returns the sequencer to its idle step; no clearing pass is needed.
`timescale 1ns / 1ps
module lcd_char_writer_glyph_cache
   import lcw_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   seq_ctrl_type  ctrl;
   dp_status_type status;

   lcw_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .status      (status),
      .ctrl        (ctrl)
   );

   lcw_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctrl        (ctrl),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
